FILE: hdl/forth_source_tokenizer_top_assert.svh
// assertion macros for the source tokenizer
// needs i_clk and i_rst_n in the scope of the module that uses it
`ifndef FORTH_SOURCE_TOKENIZER_TOP_ASSERT_SVH
`define FORTH_SOURCE_TOKENIZER_TOP_ASSERT_SVH

`ifndef SYNTH

`define FST_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("tokenizer assertion failed");

`define FST_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tokenizer assertion failed");

`define FST_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tokenizer assertion failed");

`else

`define FST_ASSERT(lbl, expr)
`define FST_ASSERT_IMPL(lbl, ante, cons)
`define FST_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: hdl/fst_pkg.sv
// types, constants and character class functions of the source tokenizer
// no dependencies
package fst_pkg;

    localparam int IDX_W = 16;
    localparam int TOK_W = 16;
    localparam int KIND_W = 3;

    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'((64'd1 << IDX_W) - 64'd1);
    localparam logic [IDX_W:0]   ORG_MAX = (IDX_W+1)'((64'd1 << IDX_W) + 64'd1);
    localparam logic [IDX_W:0]   ORG_ONE = (IDX_W+1)'(1);

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [KIND_W-1:0] K_CMD   = 3'd0;
    localparam logic [KIND_W-1:0] K_STR   = 3'd1;
    localparam logic [KIND_W-1:0] K_INT   = 3'd2;
    localparam logic [KIND_W-1:0] K_FLT   = 3'd3;
    localparam logic [KIND_W-1:0] K_FETCH = 3'd4;
    localparam logic [KIND_W-1:0] K_STORE = 3'd5;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_UP_E   = 8'h45;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_E   = 8'h65;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef enum logic [21:0] {
        LX_IDLE       = 22'd1,
        LX_INT        = 22'd2,
        LX_CMD        = 22'd4,
        LX_STR        = 22'd8,
        LX_SIGN       = 22'd16,
        LX_QUOTE      = 22'd32,
        LX_BRACE_OPEN = 22'd64,
        LX_BRACE      = 22'd128,
        LX_SLASH      = 22'd256,
        LX_BCMT       = 22'd512,
        LX_BCMT_STAR  = 22'd1024,
        LX_LCMT       = 22'd2048,
        LX_DOLLAR     = 22'd4096,
        LX_FETCH_NAME = 22'd8192,
        LX_BANG       = 22'd16384,
        LX_STORE_NAME = 22'd32768,
        LX_BANG_EQ    = 22'd65536,
        LX_DOT        = 22'd131072,
        LX_FRAC       = 22'd262144,
        LX_EXP        = 22'd524288,
        LX_EXP_SIGN   = 22'd1048576,
        LX_EXP_DIG    = 22'd2097152
    } t_lex;

    typedef struct packed {
        logic [TOK_W-1:0]  start;
        logic [TOK_W-1:0]  length;
        logic [KIND_W-1:0] kind;
        logic              last;
        logic              too_long;
    } t_tok;

    function automatic logic is_lineend(input logic [7:0] c);
        return (c == CH_CR) || (c == CH_LF) || (c == CH_NUL);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || is_lineend(c);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[CH_ZERO:CH_NINE]};
    endfunction

    function automatic logic is_exp(input logic [7:0] c);
        return (c == CH_LO_E) || (c == CH_UP_E);
    endfunction

    function automatic logic is_sign(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS);
    endfunction

    function automatic logic [IDX_W:0] inc_org(input logic [IDX_W:0] x);
        return (x < ORG_MAX) ? x + 1'b1 : x;
    endfunction

endpackage

FILE: hdl/forth_source_tokenizer_top.sv
// source tokenizer top level: lexer state, byte index and a small result queue
// depends on fst_pkg and forth_source_tokenizer_top_assert.svh
//
// usage
//   input stream: one source byte per request on i_s_axis_tdata[7:0]; a zero byte
//   ends the program, is lexed as a blank and then returns the lexer to its start
//   output stream: one token per request, tdata = start, length, kind; tlast marks
//   the final token caused by one byte, tuser flags a saturated byte index
//   a token caused by a byte is written to the result queue when that byte is taken
//   throughput: one byte per cycle while ready is high; a byte gives zero, one or
//   two tokens, so the rate is set by the four-entry result queue and the output
//   side draining it
//   ready is high while the queue has room for two tokens
//   reset: lexer between tokens, index zero, queue empty
//   a stalled receiver fills the queue and then holds off the input side
`include "forth_source_tokenizer_top_assert.svh"

module forth_source_tokenizer_top
    import fst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,     // [7:0] char_code
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,     // [15:0] token_start, [31:16] token_length,
                                            // [34:32] token_kind, [39:35] zero
    output logic        o_m_axis_tlast,     // last_of_run
    output logic [0:0]  o_m_axis_tuser      // [0] too_long
);

    t_lex             r_lex, n_lex;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W:0]   r_org, n_org;

    t_tok             r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_count, n_count;

    logic [7:0]        w_c;
    logic              w_in_acc;
    logic              w_out_acc;
    logic              w_close;
    logic              w_imp;
    logic              w_bump;
    logic [KIND_W-1:0] w_kind;
    logic [KIND_W-1:0] w_imp_kind;
    logic [IDX_W:0]    w_start;
    logic [IDX_W:0]    w_cur;
    logic [IDX_W:0]    w_len;
    logic [IDX_W:0]    w_org1;
    logic [IDX_W:0]    w_org2;
    logic              w_sat;
    logic [1:0]        w_push_n;
    t_tok              w_res0;
    t_tok              w_res1;
    t_tok              w_head;

    assign w_c       = i_s_axis_tdata;
    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc = o_m_axis_tvalid && i_m_axis_tready;

    // next lexer state and token events
    always_comb begin
        n_lex      = LX_CMD;
        w_close    = 1'b0;
        w_kind     = K_CMD;
        w_imp      = 1'b0;
        w_imp_kind = K_FETCH;
        w_bump     = 1'b0;
        case (r_lex)
            LX_INT: begin
                if (is_blank(w_c)) begin
                    w_close = 1'b1; w_kind = K_INT; n_lex = LX_IDLE;
                end else if (is_exp(w_c)) begin
                    n_lex = LX_EXP;
                end else if (w_c == CH_DOT) begin
                    n_lex = LX_DOT;
                end else if (is_digit(w_c)) begin
                    n_lex = LX_INT;
                end
            end
            LX_CMD: begin
                if (is_blank(w_c)) begin
                    w_close = 1'b1; n_lex = LX_IDLE;
                end
            end
            LX_STR, LX_QUOTE: begin
                n_lex = LX_STR;
                if (w_c == CH_QUOTE) begin
                    w_close = 1'b1; w_kind = K_STR; n_lex = LX_IDLE;
                end
            end
            LX_SIGN: begin
                if (is_blank(w_c)) begin
                    w_close = 1'b1; n_lex = LX_IDLE;
                end else if (is_digit(w_c)) begin
                    n_lex = LX_INT;
                end
            end
            LX_BRACE_OPEN: begin
                n_lex = LX_BRACE;
            end
            LX_BRACE: begin
                n_lex = LX_BRACE;
                if (w_c == CH_RBRACE) begin
                    w_close = 1'b1; n_lex = LX_IDLE;
                end
            end
            LX_SLASH: begin
                if (w_c == CH_STAR) begin
                    n_lex = LX_BCMT; w_bump = 1'b1;
                end else if (w_c == CH_SLASH) begin
                    n_lex = LX_LCMT; w_bump = 1'b1;
                end else if (is_blank(w_c)) begin
                    w_close = 1'b1; n_lex = LX_IDLE;
                end
            end
            LX_BCMT: begin
                w_bump = 1'b1;
                n_lex  = (w_c == CH_STAR) ? LX_BCMT_STAR : LX_BCMT;
            end
            LX_BCMT_STAR: begin
                w_bump = 1'b1;
                n_lex  = (w_c == CH_SLASH) ? LX_IDLE : LX_BCMT;
            end
            LX_LCMT: begin
                w_bump = 1'b1;
                n_lex  = is_lineend(w_c) ? LX_IDLE : LX_LCMT;
            end
            LX_DOLLAR: begin
                n_lex  = LX_FETCH_NAME;
                w_bump = 1'b1;
            end
            LX_FETCH_NAME: begin
                n_lex = LX_FETCH_NAME;
                if (is_blank(w_c)) begin
                    w_close = 1'b1; w_kind = K_STR; w_imp = 1'b1;
                    w_imp_kind = K_FETCH; n_lex = LX_IDLE;
                end
            end
            LX_BANG: begin
                if (w_c == CH_EQ) begin
                    n_lex = LX_BANG_EQ;
                end else if (is_blank(w_c)) begin
                    w_close = 1'b1; n_lex = LX_IDLE;
                end else begin
                    n_lex = LX_STORE_NAME; w_bump = 1'b1;
                end
            end
            LX_STORE_NAME: begin
                n_lex = LX_STORE_NAME;
                if (is_blank(w_c)) begin
                    w_close = 1'b1; w_kind = K_STR; w_imp = 1'b1;
                    w_imp_kind = K_STORE; n_lex = LX_IDLE;
                end
            end
            LX_BANG_EQ: begin
                n_lex = LX_STORE_NAME;
                if (is_blank(w_c)) begin
                    w_close = 1'b1; n_lex = LX_IDLE;
                end
            end
            LX_DOT, LX_EXP_SIGN: begin
                if (is_blank(w_c)) begin
                    w_close = 1'b1; n_lex = LX_IDLE;
                end else if ((r_lex == LX_DOT) && is_exp(w_c)) begin
                    n_lex = LX_EXP;
                end else if (is_digit(w_c)) begin
                    n_lex = (r_lex == LX_DOT) ? LX_FRAC : LX_EXP_DIG;
                end
            end
            LX_FRAC: begin
                if (is_blank(w_c)) begin
                    w_close = 1'b1; w_kind = K_FLT; n_lex = LX_IDLE;
                end else if (is_exp(w_c)) begin
                    n_lex = LX_EXP;
                end else if (is_digit(w_c)) begin
                    n_lex = LX_FRAC;
                end
            end
            LX_EXP: begin
                if (is_blank(w_c)) begin
                    w_close = 1'b1; n_lex = LX_IDLE;
                end else if (is_digit(w_c)) begin
                    n_lex = LX_EXP_DIG;
                end else if (is_sign(w_c)) begin
                    n_lex = LX_EXP_SIGN;
                end
            end
            LX_EXP_DIG: begin
                if (is_blank(w_c)) begin
                    w_close = 1'b1; w_kind = K_FLT; n_lex = LX_IDLE;
                end else if (is_digit(w_c)) begin
                    n_lex = LX_EXP_DIG;
                end
            end
            default: begin
                // between tokens
                if (w_c == CH_BANG) begin
                    n_lex = LX_BANG;
                end else if (w_c == CH_DOLLAR) begin
                    n_lex = LX_DOLLAR;
                end else if (w_c == CH_SLASH) begin
                    n_lex = LX_SLASH;
                end else if (is_blank(w_c)) begin
                    n_lex = LX_IDLE;
                end else if (w_c == CH_LBRACE) begin
                    n_lex = LX_BRACE_OPEN;
                end else if (w_c == CH_QUOTE) begin
                    n_lex = LX_QUOTE;
                end else if (is_sign(w_c)) begin
                    n_lex = LX_SIGN;
                end else if (w_c inside {[CH_LO_A:CH_LO_Z]} || (w_c == CH_DOT)) begin
                    n_lex = LX_CMD;
                end else if (is_digit(w_c)) begin
                    n_lex = LX_INT;
                end
            end
        endcase
    end

    // token bounds and origin update
    always_comb begin
        w_cur   = {1'b0, r_idx};
        w_start = r_org - 1'b1;
        w_len   = (w_cur >= w_start) ? w_cur - w_start : '0;
        w_sat   = (r_idx == IDX_MAX);
        w_org1  = w_close ? w_cur + 1'b1 : r_org;
        w_org2  = w_bump ? inc_org(w_org1) : w_org1;
        if ((n_lex == LX_IDLE) || (n_lex == LX_QUOTE) || (n_lex == LX_BRACE_OPEN)) begin
            n_org = inc_org(w_org2);
        end else begin
            n_org = w_org2;
        end
        n_idx = (r_idx < IDX_MAX) ? r_idx + 1'b1 : r_idx;
    end

    always_comb begin
        w_res0.start    = w_start[TOK_W-1:0];
        w_res0.length   = w_len[TOK_W-1:0];
        w_res0.kind     = w_kind;
        w_res0.last     = !w_imp;
        w_res0.too_long = w_sat;
        w_res1.start    = '0;
        w_res1.length   = TOK_W'(1);
        w_res1.kind     = w_imp_kind;
        w_res1.last     = 1'b1;
        w_res1.too_long = w_sat;
        w_push_n        = w_in_acc ? {1'b0, w_close} + {1'b0, w_imp} : 2'd0;
        n_wp            = r_wp + PTR_W'(w_push_n);
        n_rp            = w_out_acc ? r_rp + 1'b1 : r_rp;
        n_count         = r_count + CNT_W'(w_push_n) - CNT_W'(w_out_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lex   <= LX_IDLE;
            r_idx   <= '0;
            r_org   <= ORG_ONE;
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (w_in_acc) begin
                if (w_c == CH_NUL) begin
                    r_lex <= LX_IDLE;
                    r_idx <= '0;
                    r_org <= ORG_ONE;
                end else begin
                    r_lex <= n_lex;
                    r_idx <= n_idx;
                    r_org <= n_org;
                end
            end
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (w_push_n != 2'd0) begin
            r_fifo[r_wp] <= w_res0;
        end
        if (w_push_n == 2'd2) begin
            r_fifo[r_wp + 1'b1] <= w_res1;
        end
    end

    assign w_head          = r_fifo[r_rp];
    assign o_s_axis_tready = (r_count <= CNT_W'(FIFO_DEPTH - 2));
    assign o_m_axis_tvalid = (r_count != '0);
    assign o_m_axis_tdata  = {5'd0, w_head.kind, w_head.length, w_head.start};
    assign o_m_axis_tlast  = w_head.last;
    assign o_m_axis_tuser  = w_head.too_long;

    `FST_ASSERT(a_count_bound, r_count <= CNT_W'(FIFO_DEPTH))
    `FST_ASSERT_IMPL(a_push_fits, w_in_acc, (r_count + CNT_W'(w_push_n)) <= CNT_W'(FIFO_DEPTH))
    `FST_ASSERT_IMPL(a_pair_order, w_push_n == 2'd2, !w_res0.last && (w_res1.kind == K_FETCH || w_res1.kind == K_STORE))
    `FST_ASSERT_NEXT(a_zero_resets, w_in_acc && (w_c == CH_NUL), r_lex == LX_IDLE && r_idx == '0 && r_org == ORG_ONE)
    `FST_ASSERT_NEXT(a_index_step, w_in_acc && (w_c != CH_NUL) && (r_idx < IDX_MAX), r_idx == $past(r_idx) + 1'b1)

endmodule
